// ===== sv/ckblit_pkg.sv =====
// ----------------------------------------------------------------------------
// ckblit_pkg
// Shared types, register indexes and pixel format codes for the
// colour-keyed sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ckblit_pkg;

    // Pixel packing formats
    localparam int FMT_888 = 0;
    localparam int FMT_444 = 1;
    localparam int FMT_565 = 2;

    // Build-time defaults
    localparam int PIXEL_FORMAT_DEF = FMT_565;
    localparam int MAX_DIM_DEF      = 4096;

    // Field widths
    localparam int CHAN_W = 8;
    localparam int ADDR_W = 24;
    localparam int PIX_W  = 24;
    localparam int CFG_W  = 24;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEST_X        = 3'd0,
        CFG_DEST_Y        = 3'd1,
        CFG_BITMAP_WIDTH  = 3'd2,
        CFG_CLIP_WIDTH    = 3'd3,
        CFG_CLIP_HEIGHT   = 3'd4,
        CFG_ROW_STRIDE    = 3'd5,
        CFG_WINDOW_ORIGIN = 3'd6,
        CFG_BRIGHTNESS    = 3'd7
    } t_cfg_idx;

    // Brightness value that leaves 888 channels unscaled
    localparam logic [7:0] BRIGHT_FULL = 8'd255;

endpackage

`default_nettype wire

// ===== sv/ckblit_pack.sv =====
// ----------------------------------------------------------------------------
// ckblit_pack
// Packs one blue/green/red source pixel into the frame-buffer format
// chosen at build time (888 with brightness scaling, 444 or 565).
// ----------------------------------------------------------------------------
`default_nettype none

module ckblit_pack #(
    parameter int PIXEL_FORMAT = ckblit_pkg::PIXEL_FORMAT_DEF
) (
    input  wire logic [ckblit_pkg::CHAN_W-1:0] i_blue,
    input  wire logic [ckblit_pkg::CHAN_W-1:0] i_green,
    input  wire logic [ckblit_pkg::CHAN_W-1:0] i_red,
    input  wire logic [7:0]                    i_brightness,
    output logic      [ckblit_pkg::PIX_W-1:0]  o_pixel
);

    logic [15:0] w_blue_mul;
    logic [15:0] w_green_mul;
    logic [15:0] w_red_mul;

    // Per-channel brightness products, top byte kept
    assign w_blue_mul  = i_blue  * i_brightness;
    assign w_green_mul = i_green * i_brightness;
    assign w_red_mul   = i_red   * i_brightness;

    always_comb begin
        case (PIXEL_FORMAT)
            ckblit_pkg::FMT_888: begin
                if (i_brightness >= ckblit_pkg::BRIGHT_FULL) begin
                    o_pixel = {i_red, i_green, i_blue};
                end else begin
                    o_pixel = {w_red_mul[15:8], w_green_mul[15:8], w_blue_mul[15:8]};
                end
            end
            ckblit_pkg::FMT_444: begin
                o_pixel = {12'd0, i_red[7:4], i_green[7:4], i_blue[7:4]};
            end
            default: begin
                // 565, also used for any unknown format code
                o_pixel = {8'd0, i_red[7:3], i_green[7:2], i_blue[7:3]};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/color_keyed_sprite_blit.sv =====
// ----------------------------------------------------------------------------
// color_keyed_sprite_blit
// Colour-keyed sprite blitter: turns a raster stream of source pixels into
// frame-buffer writes, dropping black (transparent) and clipped pixels.
//
// Usage:
//   Input beats (i_valid / o_stall) carry one source pixel in raster order;
//   i_last_pixel marks the final pixel of a bitmap and restarts the counters.
//   Each input beat yields exactly one output beat (o_valid / i_stall) with
//   write enable, element address, packed pixel and an end-of-bitmap copy.
//   Address and value read zero when the write enable is low.
//   Configuration beats (i_cfg_valid / o_cfg_ready) write one register by
//   index; the port is always ready. Write it only while the block is idle.
// Timing:
//   An input register then a result register lie between input beat and
//   output beat. Throughput is one pixel per clock while the output is not
//   stalled; the frame address adder, clip compares and packer all sit in the
//   single stage. The bitmap start address is registered from configuration.
// Reset and stall:
//   Synchronous reset loads register defaults and clears the counters and
//   both pipeline stages. A stalled output holds its beat; the input register
//   keeps taking beats until it is also full, then o_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_sprite_blit #(
    parameter int PIXEL_FORMAT = ckblit_pkg::PIXEL_FORMAT_DEF,
    parameter int MAX_DIM      = ckblit_pkg::MAX_DIM_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel input
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ckblit_pkg::CHAN_W-1:0]  i_blue,
    input  wire logic [ckblit_pkg::CHAN_W-1:0]  i_green,
    input  wire logic [ckblit_pkg::CHAN_W-1:0]  i_red,
    input  wire logic                           i_last_pixel,
    // write output
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_write_enable,
    output logic      [ckblit_pkg::ADDR_W-1:0]  o_write_address,
    output logic      [ckblit_pkg::PIX_W-1:0]   o_pixel_value,
    output logic                                o_end_of_bitmap,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [ckblit_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CW  = $clog2(MAX_DIM);
    localparam int WW  = (CW + 1 > 13) ? CW + 1 : 13;
    localparam int PXW = ((CW > 16) ? CW : 16) + 2;
    localparam int PYW = 18;
    localparam int AW  = ckblit_pkg::ADDR_W;

    // configuration registers
    logic [15:0]   r_dest_x;
    logic [15:0]   r_dest_y;
    logic [12:0]   r_bmp_w;
    logic [12:0]   r_clip_w;
    logic [12:0]   r_clip_h;
    logic [15:0]   r_stride;
    logic [AW-1:0] r_origin;
    logic [7:0]    r_bright;
    logic [AW-1:0] r_start;

    // input stage
    logic                          r_a_valid;
    logic [ckblit_pkg::CHAN_W-1:0] r_a_blue;
    logic [ckblit_pkg::CHAN_W-1:0] r_a_green;
    logic [ckblit_pkg::CHAN_W-1:0] r_a_red;
    logic                          r_a_last;

    // raster position
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [AW-1:0] r_row_addr;

    // result stage
    logic                         r_b_valid;
    logic                         r_we;
    logic [AW-1:0]                r_addr;
    logic [ckblit_pkg::PIX_W-1:0] r_val;
    logic                         r_eob;

    logic                         w_adv;
    logic                         w_a_ready;
    logic [AW-1:0]                w_sy24;
    logic [AW-1:0]                w_sx24;
    logic [AW-1:0]                w_mul;
    logic [AW-1:0]                n_start;
    logic                         w_first;
    logic [AW-1:0]                w_cur_addr;
    logic signed [PXW-1:0]        w_px;
    logic signed [PYW-1:0]        w_py;
    logic                         w_vis;
    logic                         w_opaque;
    logic                         w_we;
    logic [WW-1:0]                w_col_inc;
    logic                         w_row_end;
    logic [ckblit_pkg::PIX_W-1:0] w_packed;

    // handshake: result register frees space, input register follows
    assign w_adv     = !r_b_valid || !i_stall;
    assign w_a_ready = !r_a_valid || w_adv;
    assign o_stall   = !w_a_ready;
    assign o_cfg_ready = 1'b1;

    // bitmap start address: origin + stride*dest_y + dest_x, modulo 2^24
    assign w_sy24  = {{(AW-16){r_dest_y[15]}}, r_dest_y};
    assign w_sx24  = {{(AW-16){r_dest_x[15]}}, r_dest_x};
    assign w_mul   = {{(AW-16){1'b0}}, r_stride} * w_sy24;
    assign n_start = r_origin + w_mul + w_sx24;

    // position of the pixel held in the input register
    assign w_first    = (r_col == '0) && (r_row == '0);
    assign w_cur_addr = w_first ? r_start : r_row_addr;

    // clip window test in signed arithmetic
    assign w_px = $signed({{(PXW-CW){1'b0}}, r_col})
                + $signed({{(PXW-16){r_dest_x[15]}}, r_dest_x});
    assign w_py = $signed({2'b00, r_row}) + $signed({{2{r_dest_y[15]}}, r_dest_y});
    assign w_vis = !w_px[PXW-1] && (w_px < $signed({{(PXW-13){1'b0}}, r_clip_w}))
                && !w_py[PYW-1] && (w_py < $signed({{(PYW-13){1'b0}}, r_clip_h}));

    // black is the colour key
    assign w_opaque = (r_a_blue | r_a_green | r_a_red) != '0;
    assign w_we     = w_vis && w_opaque;

    // row ends at bitmap width (zero acts as one) or at the size limit
    assign w_col_inc = {{(WW-CW){1'b0}}, r_col} + WW'(1);
    assign w_row_end = (w_col_inc >= {{(WW-13){1'b0}}, r_bmp_w})
                    || (w_col_inc == WW'(MAX_DIM));

    ckblit_pack #(
        .PIXEL_FORMAT (PIXEL_FORMAT)
    ) u_pack (
        .i_blue       (r_a_blue),
        .i_green      (r_a_green),
        .i_red        (r_a_red),
        .i_brightness (r_bright),
        .o_pixel      (w_packed)
    );

    // configuration writes and start address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x <= '0;
            r_dest_y <= '0;
            r_bmp_w  <= 13'd1;
            r_clip_w <= '0;
            r_clip_h <= '0;
            r_stride <= '0;
            r_origin <= '0;
            r_bright <= ckblit_pkg::BRIGHT_FULL;
            r_start  <= '0;
        end else begin
            r_start <= n_start;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ckblit_pkg::CFG_DEST_X:        r_dest_x <= i_cfg_data[15:0];
                    ckblit_pkg::CFG_DEST_Y:        r_dest_y <= i_cfg_data[15:0];
                    ckblit_pkg::CFG_BITMAP_WIDTH:  r_bmp_w  <= i_cfg_data[12:0];
                    ckblit_pkg::CFG_CLIP_WIDTH:    r_clip_w <= i_cfg_data[12:0];
                    ckblit_pkg::CFG_CLIP_HEIGHT:   r_clip_h <= i_cfg_data[12:0];
                    ckblit_pkg::CFG_ROW_STRIDE:    r_stride <= i_cfg_data[15:0];
                    ckblit_pkg::CFG_WINDOW_ORIGIN: r_origin <= i_cfg_data[AW-1:0];
                    ckblit_pkg::CFG_BRIGHTNESS:    r_bright <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_blue  <= i_blue;
            r_a_green <= i_green;
            r_a_red   <= i_red;
            r_a_last  <= i_last_pixel;
        end
    end

    // raster counters and row address, stepped as a pixel moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_addr <= '0;
        end else if (w_adv && r_a_valid) begin
            if (r_a_last) begin
                r_col      <= '0;
                r_row      <= '0;
                r_row_addr <= w_cur_addr;
            end else if (w_row_end) begin
                r_col      <= '0;
                r_row      <= r_row + 16'd1;
                r_row_addr <= w_cur_addr + {{(AW-16){1'b0}}, r_stride};
            end else begin
                r_col      <= r_col + CW'(1);
                r_row_addr <= w_cur_addr;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_a_valid) begin
            r_we   <= w_we;
            r_addr <= w_we ? (w_cur_addr + {{(AW-CW){1'b0}}, r_col}) : '0;
            r_val  <= w_we ? w_packed : '0;
            r_eob  <= r_a_last;
        end
    end

    assign o_valid         = r_b_valid;
    assign o_write_enable  = r_we;
    assign o_write_address = r_addr;
    assign o_pixel_value   = r_val;
    assign o_end_of_bitmap = r_eob;

endmodule

`default_nettype wire
